// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PRI_W    = 16;
    localparam int TAG_W    = 16;
    localparam int FILL_W   = 7;
    localparam int STAT_W   = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

endpackage

// ===== rtl/spq_cell.sv =====
// One compare-and-shift cell of the sorted queue chain.
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  logic       i_occ,
    input  logic       i_left_ge,
    input  t_entry     i_left,
    input  t_entry     i_right,
    output logic       o_ge,
    output t_entry     o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // new entry belongs at or ahead of this slot
    assign o_ge    = !i_occ || (r_entry.pri <= i_new.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            if (o_ge) begin
                n_entry = i_left_ge ? i_left : i_new;
            end
        end else if (i_ctrl.remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue top level: a chain of compare-and-shift cells.
// A result is registered and presented in the cycle after its input transaction.
// Throughput: one insert or remove per cycle; all cells update in parallel.
// The input is held off only while a result waits and the output is stalled.
// Reset (synchronous, active low) empties the queue and drops a pending result;
// entry storage is not cleared.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] priority_req, [31:16] value_tag
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] out_tag, [31:16] out_priority,
                                        // [38:32] fill_count, [39] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [TAG_W-1:0]  r_tag;
    logic [PRI_W-1:0]  r_pri;
    logic [FILL_W-1:0] r_fill;

    logic       accept;
    logic       full;
    logic       empty;
    t_cell_ctrl ctrl;
    t_entry     new_entry;
    t_entry     head;

    logic   [CAPACITY-1:0] ge;
    t_entry [CAPACITY-1:0] cells;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (r_count == CNT_W'(CAPACITY));
    assign empty         = (r_count == '0);

    assign new_entry.pri = s_axis_tdata[15:0];
    assign new_entry.tag = s_axis_tdata[31:16];

    assign ctrl.insert = accept && (s_axis_tuser[0] == ACT_INSERT) && !full;
    assign ctrl.remove = accept && (s_axis_tuser[0] == ACT_REMOVE) && !empty;

    assign head = cells[0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic   occ;
            logic   left_ge;
            t_entry left;
            t_entry right;

            assign occ = (r_count > CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign left_ge = 1'b0;
                assign left    = new_entry;
            end else begin : g_mid
                assign left_ge = ge[gi-1];
                assign left    = cells[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right = cells[gi];
            end else begin : g_inner
                assign right = cells[gi+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_new     (new_entry),
                .i_occ     (occ),
                .i_left_ge (left_ge),
                .i_left    (left),
                .i_right   (right),
                .o_ge      (ge[gi]),
                .o_entry   (cells[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (ctrl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        if (s_axis_tuser[0] == ACT_INSERT) begin
            n_status = full ? ST_FULL : ST_INSERTED;
        end else begin
            n_status = empty ? ST_EMPTY : ST_REMOVED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_fill   <= FILL_W'(n_count);
            r_tag    <= ctrl.remove ? head.tag : '0;
            r_pri    <= ctrl.remove ? head.pri : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {1'b0, r_fill, r_pri, r_tag};

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_protocol_checker
    import spq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_no_out_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !m_axis_tvalid
    ) else $error("result valid right after reset");

    a_zero_payload: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_REMOVED) |-> (m_axis_tdata[31:0] == 32'd0)
    ) else $error("tag or priority nonzero outside a remove");

    a_empty_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata[38:32] == 7'd0)
    ) else $error("empty status with nonzero fill count");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
    ) else $error("stalled result changed");

    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input stalled with no pending result");

endmodule

bind sorted_priority_queue spq_protocol_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/spq_checker.sv =====
// Checker for sorted_priority_queue: predicts each result from the input stream and compares.
module spq_checker
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,    // [15:0] priority_req, [31:16] value_tag
    input  logic [0:0]  i_in_user,    // [0] action
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,   // [15:0] out_tag, [31:16] out_priority,
                                      // [38:32] fill_count, [39] zero
    input  logic [1:0]  i_out_user,   // [1:0] status
    output int          o_errors,
    output int          o_outstanding
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  tag;
        logic [PRI_W-1:0]  pri;
        logic [FILL_W-1:0] fill;
    } t_result;

    logic [PRI_W-1:0] sorted_pri [CAPACITY];
    logic [TAG_W-1:0] sorted_tag [CAPACITY];
    int               sorted_count = 0;
    t_result          awaited_results[$];
    int               mismatches = 0;

    assign o_errors = mismatches;

    function automatic t_result apply_queue_op(input logic act, input logic [PRI_W-1:0] pri,
                                               input logic [TAG_W-1:0] tag);
        t_result r;
        int      pos;
        r = '0;
        if (act == ACT_INSERT) begin
            if (sorted_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < sorted_count && sorted_pri[pos] > pri) pos++;
                for (int i = sorted_count; i > pos; i--) begin
                    sorted_pri[i] = sorted_pri[i-1];
                    sorted_tag[i] = sorted_tag[i-1];
                end
                sorted_pri[pos] = pri;
                sorted_tag[pos] = tag;
                sorted_count++;
                r.status = ST_INSERTED;
            end
        end else if (sorted_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.tag = sorted_tag[0];
            r.pri = sorted_pri[0];
            for (int i = 0; i + 1 < sorted_count; i++) begin
                sorted_pri[i] = sorted_pri[i+1];
                sorted_tag[i] = sorted_tag[i+1];
            end
            sorted_count--;
            r.status = ST_REMOVED;
        end
        r.fill = FILL_W'(sorted_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            sorted_count = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d data %h",
                             $time, i_out_user, i_out_data);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 16'(want.status), 16'(i_out_user));
                    check_field("out_tag", want.tag, i_out_data[15:0]);
                    check_field("out_priority", want.pri, i_out_data[31:16]);
                    check_field("fill_count", 16'(want.fill), 16'(i_out_data[38:32]));
                    check_field("pad bit", 16'd0, 16'(i_out_data[39]));
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(apply_queue_op(i_in_user[0], i_in_data[15:0],
                                                         i_in_data[31:16]));
        end
        o_outstanding <= awaited_results.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for sorted_priority_queue: stimulus, receiver stalls, watchdog and verdict.
module tb;
    import spq_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int QUIET_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [15:0] priority_req, [31:16] value_tag
    logic [0:0]  s_axis_tuser;    // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [15:0] out_tag, [31:16] out_priority,
                                  // [38:32] fill_count, [39] zero
    logic [1:0]  m_axis_tuser;    // [1:0] status

    logic        tx_idle_en;
    logic        rx_idle_en;
    logic        rx_hold_req;
    int          errors;
    int          outstanding;
    int          quiet_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sorted_priority_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    spq_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    function automatic logic [15:0] pick_priority();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 3));
            1:       return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_op(input logic act, input logic [15:0] pri, input logic [15:0] tag);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= 1'($urandom);
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, pri};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_mixed(input int insert_pct);
        logic act;
        act = ($urandom_range(1, 100) <= insert_pct) ? ACT_INSERT : ACT_REMOVE;
        send_op(act, pick_priority(), 16'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                rx_hold_req <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sorted_priority_queue regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        tx_idle_en    <= 1'b1;
        rx_idle_en    <= 1'b1;
        rx_hold_req   <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty remove, extremes, ties at top, middle and bottom
        send_op(ACT_REMOVE, 16'hFFFF, 16'hFFFF);
        send_op(ACT_INSERT, 16'h0000, 16'h0000);
        send_op(ACT_INSERT, 16'hFFFF, 16'hFFFF);
        send_op(ACT_INSERT, 16'h8000, 16'h1234);
        send_op(ACT_INSERT, 16'h8000, 16'h5678);
        send_op(ACT_INSERT, 16'h0000, 16'hAAAA);
        send_op(ACT_INSERT, 16'hFFFF, 16'h5555);
        send_op(ACT_INSERT, 16'h7FFF, 16'h8001);
        repeat (7) send_op(ACT_REMOVE, 16'h5A5A, 16'hA5A5);
        send_op(ACT_REMOVE, 16'h0000, 16'h0000);
        send_op(ACT_INSERT, 16'h0001, 16'h0001);
        send_op(ACT_REMOVE, 16'h0000, 16'h0000);

        // long receiver hold while the sender keeps offering
        rx_hold_req <= 1'b1;
        repeat (100) send_mixed(60);
        wait_drained();

        // fill past capacity, then drain past empty
        repeat (CAPACITY + 4) send_op(ACT_INSERT, pick_priority(), 16'($urandom));
        repeat (CAPACITY + 6) send_op(ACT_REMOVE, 16'($urandom), 16'($urandom));
        wait_drained();

        repeat (150) send_mixed(50);

        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        repeat (60) send_mixed(55);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("sorted_priority_queue regression: pass");
        end else begin
            $display("sorted_priority_queue regression: fail");
        end
        $finish;
    end

endmodule
